// ===== src/pitm_pkg.sv =====
`timescale 1ns / 1ps
package pitm_pkg;

    localparam int COORD_BITS = 20;
    localparam int NODE_AW    = 16;
    localparam int TET_AW     = 16;
    localparam int MAX_NODES  = 1 << NODE_AW;
    localparam int MAX_TETRAS = 1 << TET_AW;
    localparam int CNT_W      = TET_AW + 1;
    localparam int DIFF_W     = COORD_BITS + 1;
    localparam int PROD_W     = 2 * DIFF_W;
    localparam int MINOR_W    = PROD_W + 1;
    localparam int TERM_W     = DIFF_W + MINOR_W;
    localparam int ACC_W      = TERM_W + 2;
    localparam int FQ_DEPTH   = 4;
    localparam int FQ_AW      = 2;
    localparam int FQ_CW      = FQ_AW + 1;
    localparam int DET_STEPS  = 6;
    localparam int STEP_W     = 3;
    localparam int DET_NUM    = 5;
    localparam int DET_IW     = 3;

    typedef enum logic [1:0] {
        KIND_NODE  = 2'd0,
        KIND_TETRA = 2'd1,
        KIND_QUERY = 2'd2
    } t_kind;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] x;
        logic signed [COORD_BITS-1:0] y;
        logic signed [COORD_BITS-1:0] z;
    } t_point;

    typedef struct packed {
        logic [NODE_AW-1:0] a;
        logic [NODE_AW-1:0] b;
        logic [NODE_AW-1:0] c;
        logic [NODE_AW-1:0] d;
    } t_tet;

    typedef struct packed {
        t_kind              kind;
        logic [TET_AW-1:0]  index;
        t_point             pt;
        t_tet               tet;
    } t_item;

    typedef struct packed {
        logic done;
        logic neg;
        logic zero;
    } t_det_res;

    typedef enum logic [2:0] {
        B_IDLE,
        B_TREAD,
        B_NREAD,
        B_DET,
        B_DWAIT,
        B_RESULT
    } t_bstate;

endpackage

// ===== src/pitm_front.sv =====
`timescale 1ns / 1ps
module pitm_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          push,
    output logic                          full,
    input  logic [1:0]                    i_kind,
    input  logic [pitm_pkg::TET_AW-1:0]   i_entry_index,
    input  pitm_pkg::t_point              i_pt,
    input  pitm_pkg::t_tet                i_tet,
    output logic                          o_q_valid,
    output pitm_pkg::t_item               o_q_item,
    input  logic                          i_q_pop
);

    pitm_pkg::t_item             r_mem [pitm_pkg::FQ_DEPTH];
    logic [pitm_pkg::FQ_AW-1:0]  r_wr;
    logic [pitm_pkg::FQ_AW-1:0]  r_rd;
    logic [pitm_pkg::FQ_CW-1:0]  r_cnt;
    logic                        keep;
    logic                        wr_en;
    logic                        rd_en;
    pitm_pkg::t_item             item;

    always_comb begin
        unique case (i_kind) inside
            pitm_pkg::KIND_NODE, pitm_pkg::KIND_TETRA, pitm_pkg::KIND_QUERY: keep = 1'b1;
            default: keep = 1'b0;
        endcase
    end

    always_comb begin
        item.kind  = pitm_pkg::t_kind'(i_kind);
        item.index = i_entry_index;
        item.pt    = i_pt;
        item.tet   = i_tet;
    end

    assign full      = (r_cnt == pitm_pkg::FQ_CW'(pitm_pkg::FQ_DEPTH));
    assign wr_en     = push && !full && keep;
    assign o_q_valid = (r_cnt != '0);
    assign rd_en     = i_q_pop && o_q_valid;
    assign o_q_item  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (wr_en) r_wr <= r_wr + 1'b1;
            if (rd_en) r_rd <= r_rd + 1'b1;
            if (wr_en && !rd_en) r_cnt <= r_cnt + 1'b1;
            else if (!wr_en && rd_en) r_cnt <= r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) r_mem[r_wr] <= item;
    end

endmodule

// ===== src/pitm_det.sv =====
`timescale 1ns / 1ps
module pitm_det (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  pitm_pkg::t_point   i_a,
    input  pitm_pkg::t_point   i_b,
    input  pitm_pkg::t_point   i_c,
    input  pitm_pkg::t_point   i_d,
    output pitm_pkg::t_det_res o_res
);

    localparam int DW = pitm_pkg::DIFF_W;

    logic                                r_busy;
    logic                                r_done;
    logic [pitm_pkg::STEP_W-1:0]         r_step;
    logic signed [DW-1:0]                r_u [3];
    logic signed [DW-1:0]                r_v [3];
    logic signed [DW-1:0]                r_w [3];
    logic signed [pitm_pkg::MINOR_W-1:0] r_minor;
    logic signed [pitm_pkg::ACC_W-1:0]   r_acc;

    logic [1:0]                          k;
    logic signed [DW-1:0]                ma1, mb1, ma2, mb2, uk;
    logic signed [pitm_pkg::PROD_W-1:0]  p1, p2;
    logic signed [pitm_pkg::MINOR_W-1:0] mp;
    logic signed [pitm_pkg::TERM_W-1:0]  term;
    logic                                last;

    assign k    = r_step[2:1];
    assign last = (r_step == pitm_pkg::STEP_W'(pitm_pkg::DET_STEPS - 1));

    always_comb begin
        case (k)
            2'd0: begin
                ma1 = r_v[1]; mb1 = r_w[2]; ma2 = r_v[2]; mb2 = r_w[1]; uk = r_u[0];
            end
            2'd1: begin
                ma1 = r_v[0]; mb1 = r_w[2]; ma2 = r_v[2]; mb2 = r_w[0]; uk = r_u[1];
            end
            default: begin
                ma1 = r_v[0]; mb1 = r_w[1]; ma2 = r_v[1]; mb2 = r_w[0]; uk = r_u[2];
            end
        endcase
        p1   = ma1 * mb1;
        p2   = ma2 * mb2;
        mp   = pitm_pkg::MINOR_W'(p1) - pitm_pkg::MINOR_W'(p2);
        term = uk * r_minor;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= r_busy && last;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= '0;
            end else if (r_busy) begin
                r_step <= r_step + 1'b1;
                if (last) r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_u[0] <= DW'(i_a.x) - DW'(i_d.x);
            r_u[1] <= DW'(i_a.y) - DW'(i_d.y);
            r_u[2] <= DW'(i_a.z) - DW'(i_d.z);
            r_v[0] <= DW'(i_b.x) - DW'(i_d.x);
            r_v[1] <= DW'(i_b.y) - DW'(i_d.y);
            r_v[2] <= DW'(i_b.z) - DW'(i_d.z);
            r_w[0] <= DW'(i_c.x) - DW'(i_d.x);
            r_w[1] <= DW'(i_c.y) - DW'(i_d.y);
            r_w[2] <= DW'(i_c.z) - DW'(i_d.z);
            r_acc  <= '0;
        end else if (r_busy) begin
            if (!r_step[0]) r_minor <= mp;
            else if (k == 2'd1) r_acc <= r_acc - pitm_pkg::ACC_W'(term);
            else r_acc <= r_acc + pitm_pkg::ACC_W'(term);
        end
    end

    assign o_res.done = r_done;
    assign o_res.neg  = r_acc[pitm_pkg::ACC_W-1];
    assign o_res.zero = (r_acc == '0);

endmodule

// ===== src/pitm_back.sv =====
`timescale 1ns / 1ps
module pitm_back (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [pitm_pkg::CNT_W-1:0]   i_cfg_data,
    input  logic                         i_q_valid,
    input  pitm_pkg::t_item              i_q_item,
    output logic                         o_q_pop,
    input  logic                         pop,
    output logic                         empty,
    output logic                         o_contained
);

    localparam int CW = pitm_pkg::CNT_W;

    pitm_pkg::t_bstate r_state, n_state;

    pitm_pkg::t_point  r_node_mem [pitm_pkg::MAX_NODES];
    pitm_pkg::t_tet    r_tet_mem  [pitm_pkg::MAX_TETRAS];
    pitm_pkg::t_point  r_node_rd;
    pitm_pkg::t_tet    r_tet_rd;

    logic [CW-1:0]                 r_tet_count;
    logic [CW-1:0]                 r_n;
    logic [CW-1:0]                 r_t;
    logic [2:0]                    r_nsel;
    logic [pitm_pkg::DET_IW-1:0]   r_j;
    logic                          r_s0neg;
    logic                          r_hit;
    logic                          r_out_valid;
    logic                          r_out;
    pitm_pkg::t_point              r_p;
    pitm_pkg::t_point              r_pt [4];

    logic [pitm_pkg::NODE_AW-1:0]  node_addr;
    logic                          det_start;
    logic                          node_we, tet_we;
    logic                          last_t;
    logic [CW-1:0]                 n_clamp;
    logic                          det_match;
    pitm_pkg::t_point              op [4];
    pitm_pkg::t_det_res            det_res;

    assign last_t  = ((CW + 1)'(r_t) + 1'b1) >= (CW + 1)'(r_n);
    assign n_clamp = (r_tet_count > CW'(pitm_pkg::MAX_TETRAS))
                     ? CW'(pitm_pkg::MAX_TETRAS) : r_tet_count;
    assign det_match = !det_res.zero && (det_res.neg == r_s0neg);

    always_comb begin
        case (r_nsel[1:0])
            2'd0:    node_addr = r_tet_rd.a;
            2'd1:    node_addr = r_tet_rd.b;
            2'd2:    node_addr = r_tet_rd.c;
            default: node_addr = r_tet_rd.d;
        endcase
    end

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            op[i] = (r_j == pitm_pkg::DET_IW'(i + 1)) ? r_p : r_pt[i];
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            pitm_pkg::B_IDLE: begin
                if (i_q_valid && i_q_item.kind == pitm_pkg::KIND_QUERY) begin
                    n_state = (n_clamp == '0) ? pitm_pkg::B_RESULT : pitm_pkg::B_TREAD;
                end
            end
            pitm_pkg::B_TREAD: n_state = pitm_pkg::B_NREAD;
            pitm_pkg::B_NREAD: begin
                if (r_nsel == 3'd4) n_state = pitm_pkg::B_DET;
            end
            pitm_pkg::B_DET: n_state = pitm_pkg::B_DWAIT;
            pitm_pkg::B_DWAIT: begin
                if (det_res.done) begin
                    if (r_j == '0) begin
                        if (!det_res.zero) n_state = pitm_pkg::B_DET;
                        else if (last_t) n_state = pitm_pkg::B_RESULT;
                        else n_state = pitm_pkg::B_TREAD;
                    end else if (det_match) begin
                        if (r_j == pitm_pkg::DET_IW'(pitm_pkg::DET_NUM - 1))
                            n_state = pitm_pkg::B_RESULT;
                        else n_state = pitm_pkg::B_DET;
                    end else if (last_t) begin
                        n_state = pitm_pkg::B_RESULT;
                    end else begin
                        n_state = pitm_pkg::B_TREAD;
                    end
                end
            end
            pitm_pkg::B_RESULT: begin
                if (!r_out_valid) n_state = pitm_pkg::B_IDLE;
            end
            default: n_state = pitm_pkg::B_IDLE;
        endcase
    end

    always_comb begin
        o_q_pop   = 1'b0;
        det_start = 1'b0;
        node_we   = 1'b0;
        tet_we    = 1'b0;
        unique case (r_state)
            pitm_pkg::B_IDLE: begin
                o_q_pop = i_q_valid;
                node_we = i_q_valid && i_q_item.kind == pitm_pkg::KIND_NODE;
                tet_we  = i_q_valid && i_q_item.kind == pitm_pkg::KIND_TETRA;
            end
            pitm_pkg::B_DET: det_start = 1'b1;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= pitm_pkg::B_IDLE;
            r_tet_count <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) r_tet_count <= i_cfg_data;
            if (r_state == pitm_pkg::B_RESULT && !r_out_valid) r_out_valid <= 1'b1;
            else if (pop && r_out_valid) r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            pitm_pkg::B_IDLE: begin
                r_p   <= i_q_item.pt;
                r_n   <= n_clamp;
                r_t   <= '0;
                r_hit <= 1'b0;
            end
            pitm_pkg::B_TREAD: r_nsel <= '0;
            pitm_pkg::B_NREAD: begin
                if (r_nsel != '0) r_pt[r_nsel[1:0] - 2'd1] <= r_node_rd;
                r_nsel <= r_nsel + 1'b1;
                r_j    <= '0;
            end
            pitm_pkg::B_DWAIT: begin
                if (det_res.done) begin
                    if (r_j == '0) begin
                        r_s0neg <= det_res.neg;
                        r_j     <= r_j + 1'b1;
                        if (det_res.zero) r_t <= r_t + 1'b1;
                    end else if (det_match) begin
                        r_j <= r_j + 1'b1;
                        if (r_j == pitm_pkg::DET_IW'(pitm_pkg::DET_NUM - 1)) r_hit <= 1'b1;
                    end else begin
                        r_t <= r_t + 1'b1;
                    end
                end
            end
            pitm_pkg::B_RESULT: begin
                if (!r_out_valid) r_out <= r_hit;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (node_we) r_node_mem[i_q_item.index] <= i_q_item.pt;
        r_node_rd <= r_node_mem[node_addr];
    end

    always_ff @(posedge i_clk) begin
        if (tet_we) r_tet_mem[i_q_item.index] <= i_q_item.tet;
        r_tet_rd <= r_tet_mem[r_t[pitm_pkg::TET_AW-1:0]];
    end

    pitm_det u_det (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (det_start),
        .i_a     (op[0]),
        .i_b     (op[1]),
        .i_c     (op[2]),
        .i_d     (op[3]),
        .o_res   (det_res)
    );

    assign empty       = !r_out_valid;
    assign o_contained = r_out;

endmodule

// ===== src/point_in_tetra_mesh_test_top.sv =====
`timescale 1ns / 1ps
// Point-in-tetrahedral-mesh test.
// Input channel (push/full): each beat is a node load, a tetra load or a query;
// kind 3 beats are taken and dropped. Loads write the node or tetra store and
// give no result. A query gives one beat on the result channel (empty/pop):
// o_contained is 1 if the point lies strictly inside one of tetras
// 0 .. min(tet_count, 65536)-1, tested in order, the first hit ending the walk.
// tet_count is written through i_cfg_we/i_cfg_data; the user must write it
// only while the block is idle, as the block itself does not enforce this.
// A four-entry queue sits between the input side and the walk engine.
// Loads are written from the queue head while the engine is idle. A query
// walks tetras one at a time: one tetra-store read, four node-store reads,
// then up to five determinants on a shared unit. The node-store read port
// and the determinant unit set the pace of the walk.
// Reset empties the queue and the result register and clears tet_count;
// store contents are undefined until loaded. If the receiver stalls, the
// result waits in its register, the engine holds once its next result is
// ready, and input beats are still taken until the queue is full.
module point_in_tetra_mesh_test_top (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                push,
    output logic                                full,
    input  logic [1:0]                          i_kind,
    input  logic [pitm_pkg::TET_AW-1:0]         i_entry_index,
    input  logic signed [pitm_pkg::COORD_BITS-1:0] i_coord_x,
    input  logic signed [pitm_pkg::COORD_BITS-1:0] i_coord_y,
    input  logic signed [pitm_pkg::COORD_BITS-1:0] i_coord_z,
    input  logic [pitm_pkg::NODE_AW-1:0]        i_vertex_a,
    input  logic [pitm_pkg::NODE_AW-1:0]        i_vertex_b,
    input  logic [pitm_pkg::NODE_AW-1:0]        i_vertex_c,
    input  logic [pitm_pkg::NODE_AW-1:0]        i_vertex_d,
    output logic                                empty,
    input  logic                                pop,
    output logic                                o_contained,
    input  logic                                i_cfg_we,
    input  logic [pitm_pkg::CNT_W-1:0]          i_cfg_data
);

    pitm_pkg::t_point pt;
    pitm_pkg::t_tet   tet;
    pitm_pkg::t_item  q_item;
    logic             q_valid;
    logic             q_pop;

    assign pt.x  = i_coord_x;
    assign pt.y  = i_coord_y;
    assign pt.z  = i_coord_z;
    assign tet.a = i_vertex_a;
    assign tet.b = i_vertex_b;
    assign tet.c = i_vertex_c;
    assign tet.d = i_vertex_d;

    pitm_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .push          (push),
        .full          (full),
        .i_kind        (i_kind),
        .i_entry_index (i_entry_index),
        .i_pt          (pt),
        .i_tet         (tet),
        .o_q_valid     (q_valid),
        .o_q_item      (q_item),
        .i_q_pop       (q_pop)
    );

    pitm_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data),
        .i_q_valid   (q_valid),
        .i_q_item    (q_item),
        .o_q_pop     (q_pop),
        .pop         (pop),
        .empty       (empty),
        .o_contained (o_contained)
    );

endmodule

// ===== src/pitm_checker.sv =====
`timescale 1ns / 1ps
module pitm_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic full,
    input logic empty,
    input logic pop,
    input logic o_contained
);

    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> empty)
        else $error("result channel not empty after reset");

    a_reset_not_full: assert property (@(posedge i_clk) !i_rst_n |=> !full)
        else $error("input channel full after reset");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && !pop |=> !empty && $stable(o_contained))
        else $error("waiting result changed");

    a_single_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && pop |=> empty)
        else $error("result shown again right after it was taken");

endmodule

bind point_in_tetra_mesh_test_top pitm_checker u_chk (.*);

// ===== tb/mesh_result_checker.sv =====
`timescale 1ns / 1ps
module mesh_result_checker (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   push,
    input  logic                                   full,
    input  logic [1:0]                             i_kind,
    input  logic [pitm_pkg::TET_AW-1:0]            i_entry_index,
    input  logic signed [pitm_pkg::COORD_BITS-1:0] i_coord_x,
    input  logic signed [pitm_pkg::COORD_BITS-1:0] i_coord_y,
    input  logic signed [pitm_pkg::COORD_BITS-1:0] i_coord_z,
    input  logic [pitm_pkg::NODE_AW-1:0]           i_vertex_a,
    input  logic [pitm_pkg::NODE_AW-1:0]           i_vertex_b,
    input  logic [pitm_pkg::NODE_AW-1:0]           i_vertex_c,
    input  logic [pitm_pkg::NODE_AW-1:0]           i_vertex_d,
    input  logic                                   empty,
    input  logic                                   pop,
    input  logic                                   o_contained,
    input  logic                                   i_cfg_we,
    input  logic [pitm_pkg::CNT_W-1:0]             i_cfg_data,
    output int                                     fail_count,
    output int                                     pending
);
    import pitm_pkg::*;

    typedef struct {
        longint x;
        longint y;
        longint z;
    } vec_t;

    vec_t             node_mem [int];
    logic [63:0]      corner_mem [int];
    logic [CNT_W-1:0] mesh_count;
    bit               inside_expected [$];

    function automatic int orient_sign(vec_t a, vec_t b, vec_t c, vec_t d);
        longint ux, uy, uz, vx, vy, vz, wx, wy, wz;
        logic signed [127:0] p0, p1, p2, q0, q1, q2, r;
        ux = a.x - d.x; uy = a.y - d.y; uz = a.z - d.z;
        vx = b.x - d.x; vy = b.y - d.y; vz = b.z - d.z;
        wx = c.x - d.x; wy = c.y - d.y; wz = c.z - d.z;
        p0 = ux; p1 = uy; p2 = uz;
        q0 = vy * wz - vz * wy;
        q1 = vx * wz - vz * wx;
        q2 = vx * wy - vy * wx;
        r = p0 * q0 - p1 * q1 + p2 * q2;
        if (r < 0) return -1;
        return (r == 0) ? 0 : 1;
    endfunction

    function automatic bit point_in_mesh(vec_t p);
        int n;
        int s0;
        logic [63:0] e;
        vec_t a, b, c, d;
        n = (mesh_count > MAX_TETRAS) ? MAX_TETRAS : int'(mesh_count);
        for (int t = 0; t < n; t++) begin
            e = corner_mem[t];
            a = node_mem[int'(e[63:48])];
            b = node_mem[int'(e[47:32])];
            c = node_mem[int'(e[31:16])];
            d = node_mem[int'(e[15:0])];
            s0 = orient_sign(a, b, c, d);
            if (s0 != 0 && orient_sign(p, b, c, d) == s0 && orient_sign(a, p, c, d) == s0
                && orient_sign(a, b, p, d) == s0 && orient_sign(a, b, c, p) == s0)
                return 1'b1;
        end
        return 1'b0;
    endfunction

    always @(posedge i_clk) begin
        vec_t pt;
        bit want;
        if (!i_rst_n) begin
            mesh_count = '0;
            fail_count = 0;
            inside_expected.delete();
        end else begin
            if (pop && !empty) begin
                if (inside_expected.size() == 0) begin
                    $error("contained: no result expected, actual %0d", o_contained);
                    fail_count++;
                end else begin
                    want = inside_expected.pop_front();
                    if (o_contained !== want) begin
                        $error("contained: expected %0d, actual %0d", want, o_contained);
                        fail_count++;
                    end
                end
            end
            if (i_cfg_we) mesh_count = i_cfg_data;
            if (push && !full) begin
                pt.x = i_coord_x;
                pt.y = i_coord_y;
                pt.z = i_coord_z;
                case (i_kind)
                    KIND_NODE:  node_mem[int'(i_entry_index)] = pt;
                    KIND_TETRA: corner_mem[int'(i_entry_index)] =
                        {i_vertex_a, i_vertex_b, i_vertex_c, i_vertex_d};
                    KIND_QUERY: inside_expected.push_back(point_in_mesh(pt));
                    default: ;
                endcase
            end
        end
        pending <= inside_expected.size();
    end
endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
module testbench;
    import pitm_pkg::*;

    localparam logic [1:0] KIND_UNUSED = 2'd3;
    localparam int CMAX = 524287;
    localparam int CMIN = -524288;

    logic                         i_clk;
    logic                         i_rst_n;
    logic                         push;
    logic                         full;
    logic [1:0]                   i_kind;
    logic [TET_AW-1:0]            i_entry_index;
    logic signed [COORD_BITS-1:0] i_coord_x, i_coord_y, i_coord_z;
    logic [NODE_AW-1:0]           i_vertex_a, i_vertex_b, i_vertex_c, i_vertex_d;
    logic                         empty;
    logic                         pop;
    logic                         o_contained;
    logic                         i_cfg_we;
    logic [CNT_W-1:0]             i_cfg_data;
    int                           fail_count;
    int                           pending;

    bit  quiet;
    int  pop_hold;
    int  node_x [int], node_y [int], node_z [int];
    int  node_slots [$];
    int  tet_corner [int][4];
    int  cur_count;

    point_in_tetra_mesh_test_top uut (.*);

    mesh_result_checker checker_i (.*);

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #5ms;
        $display("FAILED: results differ");
        $finish;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || quiet) begin
            pop <= 1'b1;
            pop_hold <= 0;
        end else if (pop_hold > 0) begin
            pop <= 1'b0;
            pop_hold <= pop_hold - 1;
        end else if ($urandom_range(3) == 0) begin
            pop <= 1'b0;
            pop_hold <= $urandom_range(3);
        end else begin
            pop <= 1'b1;
        end
    end

    task automatic send_beat(logic [1:0] kind, int slot, int x, int y, int z,
                             int a, int b, int c, int d);
        if (!quiet && $urandom_range(3) == 0) begin
            push <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        push <= 1'b1;
        i_kind <= kind;
        i_entry_index <= slot[TET_AW-1:0];
        i_coord_x <= x[COORD_BITS-1:0];
        i_coord_y <= y[COORD_BITS-1:0];
        i_coord_z <= z[COORD_BITS-1:0];
        i_vertex_a <= a[NODE_AW-1:0];
        i_vertex_b <= b[NODE_AW-1:0];
        i_vertex_c <= c[NODE_AW-1:0];
        i_vertex_d <= d[NODE_AW-1:0];
        @(posedge i_clk);
        while (full) @(posedge i_clk);
    endtask

    task automatic load_node(int slot, int x, int y, int z);
        if (!node_x.exists(slot)) node_slots.push_back(slot);
        node_x[slot] = x;
        node_y[slot] = y;
        node_z[slot] = z;
        send_beat(KIND_NODE, slot, x, y, z, $urandom, $urandom, $urandom, $urandom);
    endtask

    task automatic load_tet(int slot, int a, int b, int c, int d);
        tet_corner[slot][0] = a;
        tet_corner[slot][1] = b;
        tet_corner[slot][2] = c;
        tet_corner[slot][3] = d;
        send_beat(KIND_TETRA, slot, $urandom, $urandom, $urandom, a, b, c, d);
    endtask

    task automatic query(int x, int y, int z);
        send_beat(KIND_QUERY, $urandom, x, y, z, $urandom, $urandom, $urandom, $urandom);
    endtask

    task automatic query_centroid(int t);
        longint sx, sy, sz;
        sx = 0; sy = 0; sz = 0;
        for (int k = 0; k < 4; k++) begin
            sx += node_x[tet_corner[t][k]];
            sy += node_y[tet_corner[t][k]];
            sz += node_z[tet_corner[t][k]];
        end
        query(int'(sx / 4), int'(sy / 4), int'(sz / 4));
    endtask

    task automatic set_count(int n);
        push <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_data <= n[CNT_W-1:0];
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        cur_count = n;
    endtask

    function automatic int rand_coord();
        int r;
        r = $urandom;
        if ($urandom_range(3) == 0) return $signed(r[COORD_BITS-1:0]);
        return $signed(r[10:0]) * 256;
    endfunction

    function automatic int pick_node();
        return node_slots[$urandom_range(node_slots.size() - 1)];
    endfunction

    task automatic load_rand_tet(int slot);
        load_tet(slot, pick_node(), pick_node(), pick_node(), pick_node());
    endtask

    initial begin
        int t;
        quiet = 1'b0;
        i_rst_n = 1'b0;
        push = 1'b0;
        pop = 1'b0;
        i_kind = KIND_NODE;
        i_entry_index = '0;
        i_coord_x = '0;
        i_coord_y = '0;
        i_coord_z = '0;
        i_vertex_a = '0;
        i_vertex_b = '0;
        i_vertex_c = '0;
        i_vertex_d = '0;
        i_cfg_we = 1'b0;
        i_cfg_data = '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        set_count(131071);
        set_count(65536);
        set_count(0);
        query(0, 0, 0);
        load_node(0, CMIN, CMIN, CMIN);
        load_node(65535, CMAX, CMIN, CMIN);
        load_node(1, CMIN, CMAX, CMIN);
        load_node(2, CMIN, CMIN, CMAX);
        load_node(3, 0, 0, 0);
        load_node(4, CMAX, CMAX, CMIN);
        load_tet(0, 0, 65535, 1, 2);
        load_tet(1, 0, 65535, 1, 4);
        load_tet(2, 65535, 0, 1, 2);
        load_tet(65535, 3, 3, 3, 3);
        send_beat(KIND_UNUSED, 65535, CMAX, CMAX, CMAX, 65535, 65535, 65535, 65535);
        query(0, 0, 0);
        set_count(2);
        query_centroid(0);
        query(CMIN, CMIN, CMIN);
        query(CMAX, CMAX, CMAX);
        query(CMIN + 1, CMIN + 1, CMIN + 1);
        query(-1, -1, CMIN);
        set_count(3);
        query_centroid(2);
        query(CMIN + 2, 0, 0);

        for (int ph = 0; ph < 10; ph++) begin
            if (ph >= 8) quiet = 1'b1;
            set_count($urandom_range(1, 8));
            for (t = 0; t < cur_count; t++)
                if (!tet_corner.exists(t)) load_rand_tet(t);
            for (int i = 0; i < 10; i++) begin
                case ($urandom_range(19))
                    0, 1, 2, 3: load_node($urandom_range(65535), rand_coord(), rand_coord(),
                                          rand_coord());
                    4, 5, 6: load_rand_tet($urandom_range(cur_count - 1));
                    7: load_rand_tet($urandom_range(65535));
                    8: send_beat(KIND_UNUSED, $urandom, $urandom, $urandom, $urandom,
                                 $urandom, $urandom, $urandom, $urandom);
                    9, 10: query(rand_coord(), rand_coord(), rand_coord());
                    11: begin
                        t = pick_node();
                        query(node_x[t], node_y[t], node_z[t]);
                    end
                    default: query_centroid($urandom_range(cur_count - 1));
                endcase
            end
        end

        push <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end
endmodule
